### sv/kdlp_pkg.sv
// shared types and constants of the key debounce and long press block
package kdlp_pkg;

  // input item modes; code 3 is reserved and changes nothing
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_SCAN  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PRESS_NONE    = 2'd0,
    PRESS_SHORT   = 2'd1,
    PRESS_LONG    = 2'd2,
    PRESS_RELEASE = 2'd3
  } press_t;

  typedef enum logic [2:0] {
    EDGE_NULL    = 3'd0,
    EDGE_RISING  = 3'd1,
    EDGE_FALLING = 3'd2,
    EDGE_HOLDING = 3'd3,
    EDGE_ERROR   = 3'd4
  } edge_t;

  // configuration register indexes; index 3 writes nothing
  typedef enum logic [1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_ACTIVE_LOW = 2'd2
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] DEBOUNCE_RST   = 8'd2;
  localparam logic [7:0] LONG_PRESS_RST = 8'd150;
  localparam logic       ACTIVE_LOW_RST = 1'b1;
  localparam logic [7:0] LONG_PRESS_DEF = 8'd120;

endpackage

### sv/kdlp_if.sv
// valid/ready channel interfaces for key items and key results
interface kdlp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [1:0] key_index;
  logic       pin_level;

  modport source (output valid, mode, key_index, pin_level, input ready);
  modport sink   (input valid, mode, key_index, pin_level, output ready);
endinterface

interface kdlp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_state;
  logic [2:0] edge_code;

  modport source (output valid, key_state, edge_code, input ready);
  modport sink   (input valid, key_state, edge_code, output ready);
endinterface

### sv/key_debounce_long_press.sv
// top level: debounce and press classification for a bank of push keys
//
// The block takes one item per clock while the output side is not stalled and gives exactly
// one result per item, in order. An item is captured in an input register, processed by the
// per-key update logic and lands in the result register once that register is free or being
// emptied. Throughput is one item per cycle under that condition, set by the read-modify-write
// of the selected key's state; the result register lets the next item enter while a finished
// result waits. All keys share the debounce, long press and polarity registers. They are to be
// written by the user through the cfg port while no item is in flight; the block itself does
// not enforce this.
module key_debounce_long_press
  import kdlp_pkg::*;
#(
  parameter int KEYS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  kdlp_in_if.sink               in_ch,
  kdlp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;

  // configuration
  logic [7:0] debounce_r;
  logic [7:0] long_press_r;
  logic       active_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
      active_low_r <= ACTIVE_LOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata;
        CFG_LONG_PRESS: long_press_r <= cfg_wdata;
        CFG_ACTIVE_LOW: active_low_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic       s1_valid_r;
  logic [1:0] s1_mode_r;
  logic [1:0] s1_key_r;
  logic       s1_pin_r;
  logic       o_valid_r;
  logic       advance;
  logic       in_xfer;

  // the item in stage 1 moves on whenever the result register is free or being emptied
  assign advance      = s1_valid_r && (!o_valid_r || out_ch.ready);
  // no transfer while reset is held, so nothing is dropped by it
  assign in_ch.ready  = rst_n && (!s1_valid_r || advance);
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r <= in_ch.mode;
      s1_key_r  <= in_ch.key_index;
      s1_pin_r  <= in_ch.pin_level;
    end
  end

  // per-key state
  logic [KEYS-1:0] sampled_r, sampled_nxt;
  logic [KEYS-1:0] settled_r, settled_nxt;
  logic [7:0]      cd_r       [KEYS];
  logic [7:0]      cd_nxt     [KEYS];
  press_t          press_r    [KEYS];
  press_t          press_nxt  [KEYS];
  press_t          report_r   [KEYS];
  press_t          report_nxt [KEYS];

  logic [KW-1:0] idx;
  logic          key_ok;
  logic [1:0]    state_res;
  edge_t         edge_res;

  // keys beyond the bank are ignored by scans and queries
  assign idx    = KW'(s1_key_r);
  assign key_ok = 32'(s1_key_r) < KEYS;

  always_comb begin
    logic       lvl;
    logic       samp;
    logic       setl;
    logic [7:0] cd;
    press_t     ps;
    press_t     last;

    sampled_nxt = sampled_r;
    settled_nxt = settled_r;
    cd_nxt      = cd_r;
    press_nxt   = press_r;
    report_nxt  = report_r;
    edge_res    = EDGE_NULL;

    lvl  = s1_pin_r ^ active_low_r;
    samp = sampled_r[idx];
    setl = settled_r[idx];
    cd   = cd_r[idx];
    ps   = press_r[idx];
    last = report_r[idx];

    unique case (mode_t'(s1_mode_r))
      MODE_TICK: begin
        // every running countdown steps down by one
        for (int i = 0; i < KEYS; i++) begin
          if (cd_r[i] != 8'd0) cd_nxt[i] = cd_r[i] - 8'd1;
        end
      end
      MODE_SCAN: begin
        if (key_ok) begin
          // level change restarts the debounce window
          if (samp != lvl) begin
            samp = lvl;
            cd   = debounce_r;
          end
          // level held long enough: take it as settled
          if (setl != samp && cd == 8'd0) begin
            if (samp) begin
              ps = PRESS_SHORT;
              cd = (long_press_r != 8'd0) ? long_press_r : LONG_PRESS_DEF;
            end else begin
              ps = PRESS_RELEASE;
            end
            setl = samp;
          end
          // short press that outlived the long press window
          if (ps == PRESS_SHORT && cd == 8'd0) ps = PRESS_LONG;
          sampled_nxt[idx] = samp;
          settled_nxt[idx] = setl;
          cd_nxt[idx]      = cd;
          press_nxt[idx]   = ps;
        end
      end
      MODE_QUERY: begin
        if (key_ok) begin
          priority if (ps == last) begin
            edge_res = EDGE_NULL;
          end else if (ps == PRESS_SHORT &&
                       (last == PRESS_NONE || last == PRESS_RELEASE)) begin
            edge_res = EDGE_RISING;
          end else if (ps == PRESS_RELEASE &&
                       (last == PRESS_SHORT || last == PRESS_LONG)) begin
            edge_res = EDGE_FALLING;
          end else if (ps == PRESS_LONG && last == PRESS_SHORT) begin
            edge_res = EDGE_HOLDING;
          end else begin
            edge_res = EDGE_ERROR;
          end
          report_nxt[idx] = ps;
        end
      end
      default: ;
    endcase

    state_res = key_ok ? 2'(ps) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sampled_r <= '0;
      settled_r <= '0;
      for (int i = 0; i < KEYS; i++) begin
        cd_r[i]     <= 8'd0;
        press_r[i]  <= PRESS_NONE;
        report_r[i] <= PRESS_NONE;
      end
    end else if (advance) begin
      sampled_r <= sampled_nxt;
      settled_r <= settled_nxt;
      cd_r      <= cd_nxt;
      press_r   <= press_nxt;
      report_r  <= report_nxt;
    end
  end

  // result register
  logic [1:0] o_state_r;
  logic [2:0] o_edge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (advance) begin
      o_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_state_r <= state_res;
      o_edge_r  <= 3'(edge_res);
    end
  end

  assign out_ch.valid     = o_valid_r;
  assign out_ch.key_state = o_state_r;
  assign out_ch.edge_code = o_edge_r;

endmodule

### sv/kdlp_checker.sv
// port-level checks of the key debounce block, bound to its top level
module kdlp_checker
  import kdlp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] key_state,
  input logic [2:0] edge_code
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(key_state) && $stable(edge_code))
    else $error("result changed while stalled");

  // edge codes stay within the defined set
  a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> edge_code <= 3'(EDGE_ERROR))
    else $error("edge code out of range");

  // a result that appears on an empty output came from an input transfer through the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching input transfer");

  // with the output stalled and no new result moving, a full pipe takes no input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && $past(out_valid && !out_ready) && $past(in_valid && in_ready)
    |-> !in_ready)
    else $error("input taken with both stages full");

endmodule

bind key_debounce_long_press kdlp_checker u_kdlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .key_state (out_ch.key_state),
  .edge_code (out_ch.edge_code)
);
